FILE: hw/rtl/tknl_pkg.sv
package tknl_pkg;

  localparam int CAPACITY   = 64;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int SCORE_W    = 32;
  localparam int ID_W       = 32;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 4;
  localparam int SIZE_W     = 7;
  localparam int LIMIT_W    = 7;
  localparam int CMP_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_LIST_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_ALL   = CFG_IDX_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_OFFER = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 4'd0,
    ST_REPLACED = 4'd1,
    ST_TIE      = 4'd2,
    ST_DUP      = 4'd3,
    ST_NOT_GOOD = 4'd4,
    ST_DROPPED  = 4'd5,
    ST_ENTRY    = 4'd6,
    ST_CLEARED  = 4'd7,
    ST_EMPTY    = 4'd8
  } status_t;

  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/tknl_if.sv
interface tknl_req_if import tknl_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [SCORE_W-1:0] score;
  logic [ID_W-1:0]           cand_id;

  modport source (output valid, cmd, score, cand_id, input ready);
  modport sink   (input valid, cmd, score, cand_id, output ready);
endinterface

interface tknl_rsp_if import tknl_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [SCORE_W-1:0] out_score;
  logic [ID_W-1:0]           out_id;
  logic                      evicted_valid;
  logic [ID_W-1:0]           evicted_id;
  logic [SIZE_W-1:0]         list_size;
  logic                      last;

  modport source (output valid, status, out_score, out_id, evicted_valid, evicted_id,
                  list_size, last, input ready);
  modport sink   (input valid, status, out_score, out_id, evicted_valid, evicted_id,
                  list_size, last, output ready);
endinterface

FILE: hw/rtl/tknl_cell.sv
module tknl_cell import tknl_pkg::*; (
  input  logic                      clk,
  input  cell_ctl_t                 ctl,
  input  logic                      occ,
  input  logic                      tail,
  input  logic signed [SCORE_W-1:0] cand_score,
  input  logic [ID_W-1:0]           cand_id,
  input  logic                      prev_le,
  input  logic signed [SCORE_W-1:0] prev_score,
  input  logic [ID_W-1:0]           prev_id,
  input  logic signed [SCORE_W-1:0] next_score,
  input  logic [ID_W-1:0]           next_id,
  input  logic signed [SCORE_W-1:0] head_score,
  input  logic [ID_W-1:0]           head_id,
  output logic signed [SCORE_W-1:0] score,
  output logic [ID_W-1:0]           id,
  output logic                      le,
  output logic                      eq,
  output logic                      match
);

  always_ff @(posedge clk) begin
    le    <= occ && (score <= cand_score);
    eq    <= occ && (score == cand_score);
    match <= occ && (id == cand_id);
    if (ctl.insert && !le) begin
      if (prev_le) begin
        score <= cand_score;
        id    <= cand_id;
      end else begin
        score <= prev_score;
        id    <= prev_id;
      end
    end else if (ctl.rotate) begin
      if (tail) begin
        score <= head_score;
        id    <= head_id;
      end else begin
        score <= next_score;
        id    <= next_id;
      end
    end
  end

endmodule

FILE: hw/rtl/topk_neighbor_list_dedup.sv
// channel | dir | payload                                              | accepted when
// req     | in  | cmd, score, cand_id                                  | valid & ready
// rsp     | out | status, out_score, out_id, evicted_valid, evicted_id, | valid & ready
//         |     | list_size, last                                      |
// cfg     | in  | cfg_index, cfg_data                                  | cfg_we
// An offer is compared in every cell, then decided: the result is registered and an insert
// shifts the cell row once. Readout gives one entry a cycle from the head cell as the row
// rotates, unless rsp stalls; clear and empty readout answer from S_RESP. Reset is synchronous
// and empties the list at once. A stalled rsp holds the row: no cell moves until the output
// register is free, and req is taken again only once the current request is finished.
module topk_neighbor_list_dedup import tknl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tknl_req_if.sink              req,
  tknl_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_DECIDE,
    S_READ,
    S_RESP
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          rd_left;
  logic [LIMIT_W-1:0]        list_limit;
  logic                      keep_all;
  logic [CMD_W-1:0]          cmd_r;
  logic signed [SCORE_W-1:0] s_r;
  logic [ID_W-1:0]           cid_r;
  logic [ID_W-1:0]           evid;

  logic                      out_valid;
  logic [STATUS_W-1:0]       out_status;
  logic signed [SCORE_W-1:0] out_score;
  logic [ID_W-1:0]           out_id;
  logic                      out_ev;
  logic [ID_W-1:0]           out_evid;
  logic [SIZE_W-1:0]         out_size;
  logic                      out_last;

  logic signed [SCORE_W-1:0] cell_score [CAPACITY];
  logic [ID_W-1:0]           cell_id    [CAPACITY];
  logic [CAPACITY-1:0]       le_v, eq_v, match_v, occ, tail;
  logic [ID_W-1:0]           sel_id;
  cell_ctl_t                 ctl;
  logic                      slot_free;

  logic                      dup, room, full, tail_le, tail_eq;
  logic                      do_ins;
  status_t                   dec_status;
  logic [CNT_W-1:0]          count_next;

  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.out_score     = out_score;
  assign rsp.out_id        = out_id;
  assign rsp.evicted_valid = out_ev;
  assign rsp.evicted_id    = out_evid;
  assign rsp.list_size     = out_size;
  assign rsp.last          = out_last;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = CNT_W'(i) < count;
    end
    tail = occ & ~{1'b0, occ[CAPACITY-1:1]};
  end

  always_comb begin
    sel_id = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tail[i]) begin
        sel_id = sel_id | cell_id[i];
      end
    end
  end

  assign ctl.insert = (state == S_DECIDE) && slot_free && do_ins;
  assign ctl.rotate = (state == S_READ) && slot_free;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      p_le;
    logic signed [SCORE_W-1:0] p_score, n_score;
    logic [ID_W-1:0]           p_id, n_id;

    if (i == 0) begin : g_first
      assign p_le    = 1'b1;
      assign p_score = cell_score[i];
      assign p_id    = cell_id[i];
    end else begin : g_rest
      assign p_le    = le_v[i-1];
      assign p_score = cell_score[i-1];
      assign p_id    = cell_id[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign n_score = cell_score[i];
      assign n_id    = cell_id[i];
    end else begin : g_mid
      assign n_score = cell_score[i+1];
      assign n_id    = cell_id[i+1];
    end

    tknl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ[i]),
      .tail       (tail[i]),
      .cand_score (s_r),
      .cand_id    (cid_r),
      .prev_le    (p_le),
      .prev_score (p_score),
      .prev_id    (p_id),
      .next_score (n_score),
      .next_id    (n_id),
      .head_score (cell_score[0]),
      .head_id    (cell_id[0]),
      .score      (cell_score[i]),
      .id         (cell_id[i]),
      .le         (le_v[i]),
      .eq         (eq_v[i]),
      .match      (match_v[i])
    );
  end

  always_comb begin
    dup        = |match_v;
    tail_le    = |(le_v & tail);
    tail_eq    = |(eq_v & tail);
    full       = count >= CNT_W'(CAPACITY);
    room       = keep_all || (count == '0) || (CMP_W'(count) < CMP_W'(list_limit));
    do_ins     = 1'b0;
    dec_status = ST_DUP;
    count_next = count;
    if (dup) begin
      dec_status = ST_DUP;
    end else if (room) begin
      if (full) begin
        dec_status = ST_DROPPED;
      end else begin
        dec_status = ST_INSERTED;
        do_ins     = 1'b1;
        count_next = count + CNT_W'(1);
      end
    end else if (tail_le && !tail_eq) begin
      dec_status = ST_NOT_GOOD;
    end else if (!tail_eq) begin
      dec_status = ST_REPLACED;
      do_ins     = 1'b1;
    end else if (full) begin
      dec_status = ST_DROPPED;
    end else begin
      dec_status = ST_TIE;
      do_ins     = 1'b1;
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      list_limit <= LIMIT_RESET;
      keep_all   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LIST_LIMIT: list_limit <= LIMIT_W'(cfg_data);
          REG_KEEP_ALL:   keep_all   <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_r <= req.cmd;
            s_r   <= req.score;
            cid_r <= req.cand_id;
            case (cmd_t'(req.cmd))
              CMD_OFFER: state <= S_CMP;
              CMD_READ: begin
                rd_left <= count;
                state   <= (count == '0) ? S_RESP : S_READ;
              end
              CMD_CLEAR: state <= S_RESP;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_CMP: begin
          evid  <= sel_id;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_status <= dec_status;
            out_score  <= s_r;
            out_id     <= cid_r;
            out_ev     <= (dec_status == ST_REPLACED);
            out_evid   <= (dec_status == ST_REPLACED) ? evid : '0;
            out_size   <= SIZE_W'(count_next);
            out_last   <= 1'b1;
            count      <= count_next;
            state      <= S_IDLE;
          end
        end
        S_READ: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_status <= ST_ENTRY;
            out_score  <= cell_score[0];
            out_id     <= cell_id[0];
            out_ev     <= 1'b0;
            out_evid   <= '0;
            out_size   <= SIZE_W'(count);
            out_last   <= (rd_left == CNT_W'(1));
            rd_left    <= rd_left - CNT_W'(1);
            if (rd_left == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        S_RESP: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_score <= '0;
            out_id    <= '0;
            out_ev    <= 1'b0;
            out_evid  <= '0;
            out_last  <= 1'b1;
            if (cmd_t'(cmd_r) == CMD_CLEAR) begin
              out_status <= ST_CLEARED;
              out_size   <= '0;
              count      <= '0;
            end else begin
              out_status <= ST_EMPTY;
              out_size   <= SIZE_W'(count);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_ids_unique: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> $onehot0(match_v))
    else $error("same id held in two cells");

  a_read_holds_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> $stable(count))
    else $error("count changed during readout");

  a_evict_is_replace: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ev) |-> (out_status == ST_REPLACED))
    else $error("eviction flagged on a non-replace result");

  a_no_insert_rotate: assert property (@(posedge clk) disable iff (rst)
    (ctl.rotate |-> !ctl.insert) and (ctl.insert |-> !full || (dec_status == ST_REPLACED)))
    else $error("illegal cell row operation");

endmodule

FILE: tb/topk_neighbor_list_dedup_tb.sv
module topk_neighbor_list_dedup_tb;
  import tknl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int LONG_STALL = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           cand_id;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [SCORE_W-1:0] out_score;
    logic [ID_W-1:0]           out_id;
    logic                      evicted_valid;
    logic [ID_W-1:0]           evicted_id;
    logic [SIZE_W-1:0]         list_size;
    logic                      last;
  } result_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tknl_req_if req_ch();
  tknl_rsp_if rsp_ch();

  topk_neighbor_list_dedup dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // neighbor list as the block should hold it
  logic signed [SCORE_W-1:0] nb_score [CAPACITY];
  logic [ID_W-1:0]           nb_id [CAPACITY];
  int                        nb_count;
  logic [LIMIT_W-1:0]        limit_q;
  logic                      keep_all_q;

  request_t pending_cmds[$];
  result_t  awaited_results[$];
  request_t offered;
  result_t  got;
  result_t  want;

  int send_gap_pct;
  int take_gap_pct;
  int stall_asked;
  int stall_served;
  int stall_left;
  int quiet_cycles;
  int mismatch_count;

  function automatic void nb_insert(logic signed [SCORE_W-1:0] s, logic [ID_W-1:0] id);
    int pos;
    pos = 0;
    while (pos < nb_count && nb_score[pos] <= s) pos++;
    for (int k = nb_count; k > pos; k--) begin
      nb_score[k] = nb_score[k-1];
      nb_id[k] = nb_id[k-1];
    end
    nb_score[pos] = s;
    nb_id[pos] = id;
    nb_count++;
  endfunction

  function automatic void apply_to_list(request_t r);
    result_t e;
    logic [ID_W-1:0] gone;
    bit held;
    e = '0;
    e.last = 1'b1;
    case (r.cmd)
      CMD_OFFER: begin
        e.out_score = r.score;
        e.out_id = r.cand_id;
        held = 1'b0;
        for (int k = 0; k < nb_count; k++) if (nb_id[k] == r.cand_id) held = 1'b1;
        if (held) begin
          e.status = ST_DUP;
        end else if (keep_all_q || nb_count == 0 || nb_count < limit_q) begin
          if (nb_count >= CAPACITY) begin
            e.status = ST_DROPPED;
          end else begin
            nb_insert(r.score, r.cand_id);
            e.status = ST_INSERTED;
          end
        end else if (r.score > nb_score[nb_count-1]) begin
          e.status = ST_NOT_GOOD;
        end else if (r.score != nb_score[nb_count-1]) begin
          gone = nb_id[nb_count-1];
          nb_count--;
          nb_insert(r.score, r.cand_id);
          e.status = ST_REPLACED;
          e.evicted_valid = 1'b1;
          e.evicted_id = gone;
        end else if (nb_count >= CAPACITY) begin
          e.status = ST_DROPPED;
        end else begin
          nb_insert(r.score, r.cand_id);
          e.status = ST_TIE;
        end
        e.list_size = SIZE_W'(nb_count);
        awaited_results.push_back(e);
      end
      CMD_READ: begin
        e.list_size = SIZE_W'(nb_count);
        if (nb_count == 0) begin
          e.status = ST_EMPTY;
          awaited_results.push_back(e);
        end else begin
          for (int k = 0; k < nb_count; k++) begin
            e.status = ST_ENTRY;
            e.out_score = nb_score[k];
            e.out_id = nb_id[k];
            e.last = (k == nb_count - 1);
            awaited_results.push_back(e);
          end
        end
      end
      CMD_CLEAR: begin
        nb_count = 0;
        e.status = ST_CLEARED;
        awaited_results.push_back(e);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic request_t make_cmd(logic [CMD_W-1:0] c, logic signed [SCORE_W-1:0] s,
                                        logic [ID_W-1:0] id);
    request_t r;
    r.cmd = c;
    r.score = s;
    r.cand_id = id;
    return r;
  endfunction

  function automatic request_t random_request(bit allow_clear, bit wide_ids);
    request_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) r.cmd = CMD_READ;
    else if (allow_clear && pick < 12) r.cmd = CMD_CLEAR;
    else if (pick >= 12 && pick < 14) r.cmd = CMD_UNUSED;
    else r.cmd = CMD_OFFER;
    if ($urandom_range(3) == 0) r.score = $urandom;
    else r.score = $urandom_range(30) - 15;
    if (wide_ids || $urandom_range(3) == 0) r.cand_id = $urandom;
    else r.cand_id = $urandom_range(40);
    return r;
  endfunction

  task automatic drain();
    @(negedge clk);
    while (pending_cmds.size() != 0 || req_ch.valid || awaited_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LIST_LIMIT) limit_q = LIMIT_W'(val);
    else keep_all_q = val[0];
  endtask

  task automatic run_phase(int lim, bit keep, int send_pct, int take_pct, int count,
                           bit allow_clear, bit wide_ids, bit long_hold);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_LIST_LIMIT, CFG_DATA_W'(lim));
    write_reg(REG_KEEP_ALL, CFG_DATA_W'(keep));
    @(negedge clk);
    send_gap_pct = send_pct;
    take_gap_pct = take_pct;
    if (long_hold) stall_asked++;
    for (int k = 0; k < count / 2; k++) pending_cmds.push_back(random_request(allow_clear, wide_ids));
    // hold the sender until the list is quiet, then carry on
    drain();
    for (int k = count / 2; k < count; k++)
      pending_cmds.push_back(random_request(allow_clear, wide_ids));
  endtask

  task automatic note_mismatch(string what, result_t exp_r, result_t act_r);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected st=%0d sc=%0d id=%0h ev=%0d evid=%0h n=%0d last=%0d, got st=%0d sc=%0d id=%0h ev=%0d evid=%0h n=%0d last=%0d",
               what, exp_r.status, exp_r.out_score, exp_r.out_id, exp_r.evicted_valid,
               exp_r.evicted_id, exp_r.list_size, exp_r.last, act_r.status, act_r.out_score,
               act_r.out_id, act_r.evicted_valid, act_r.evicted_id, act_r.list_size,
               act_r.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) apply_to_list(offered);
      if (req_ch.valid && !req_ch.ready) begin
      end else if (pending_cmds.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        offered = pending_cmds.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.cmd <= offered.cmd;
        req_ch.score <= offered.score;
        req_ch.cand_id <= offered.cand_id;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (stall_asked != stall_served) begin
      stall_served++;
      stall_left = LONG_STALL;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status = rsp_ch.status;
      got.out_score = rsp_ch.out_score;
      got.out_id = rsp_ch.out_id;
      got.evicted_valid = rsp_ch.evicted_valid;
      got.evicted_id = rsp_ch.evicted_id;
      got.list_size = rsp_ch.list_size;
      got.last = rsp_ch.last;
      if (awaited_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) note_mismatch("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = '0;
    req_ch.score = '0;
    req_ch.cand_id = '0;
    rsp_ch.ready = 1'b0;
    nb_count = 0;
    limit_q = LIMIT_RESET;
    keep_all_q = 1'b0;
    send_gap_pct = 19;
    take_gap_pct = 80;
    stall_asked = 0;
    stall_served = 0;
    quiet_cycles = 0;
    mismatch_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_LIST_LIMIT, CFG_DATA_W'(4));
    write_reg(REG_KEEP_ALL, CFG_DATA_W'(0));
    @(negedge clk);
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 100, 1));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 100, 1));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 32'sh8000_0000, 32'h0000_0000));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 32'sh7FFF_FFFF, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 50, 2));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 32'sh7FFF_FFFF, 3));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 60, 4));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 32'sh7FFF_FFFF, 5));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 200, 6));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 1000, 7));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 5000, 8));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_UNUSED, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 7, 9));
    pending_cmds.push_back(make_cmd(CMD_OFFER, -7, 10));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0));

    run_phase(8, 1'b0, 19, 80, 36, 1'b1, 1'b0, 1'b0);
    run_phase(1, 1'b0, 19, 80, 36, 1'b1, 1'b0, 1'b0);
    run_phase(64, 1'b1, 19, 80, 90, 1'b0, 1'b1, 1'b0);

    // probe the full list: tie at the worst score, then a better offer
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_KEEP_ALL, CFG_DATA_W'(0));
    @(negedge clk);
    if (nb_count > 0)
      pending_cmds.push_back(make_cmd(CMD_OFFER, nb_score[nb_count-1], 32'h5A5A_0001));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 32'sh8000_0000, 32'h5A5A_0002));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0));

    run_phase(3, 1'b0, 80, 19, 36, 1'b1, 1'b0, 1'b0);
    run_phase(63, 1'b0, 80, 19, 36, 1'b1, 1'b0, 1'b0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_LIST_LIMIT, CFG_DATA_W'(0));
    @(negedge clk);
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 5, 100));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 9, 101));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 5, 102));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 1, 103));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0));

    run_phase(0, 1'b0, 80, 19, 30, 1'b1, 1'b0, 1'b0);
    run_phase($urandom_range(1, 64), 1'($urandom_range(1)), 0, 0, 40, 1'b1, 1'b0, 1'b1);
    run_phase(64, 1'b0, 0, 0, 40, 1'b1, 1'b0, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
